// ===== rtl/core/wfr_pkg.sv =====
// ----------------------------------------------------------------------------
// wfr_pkg
// Shared types, register indexes and the CRC-8 helper for the frame receiver.
// ----------------------------------------------------------------------------
package wfr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FRAME_END_CODE      = 3'd0;
    localparam logic [2:0] CFG_ESCAPE_CODE         = 3'd1;
    localparam logic [2:0] CFG_ESCAPED_END_CODE    = 3'd2;
    localparam logic [2:0] CFG_ESCAPED_ESCAPE_CODE = 3'd3;
    localparam logic [2:0] CFG_CRC_SEED            = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_FRAME_END_CODE      = 8'd192;
    localparam logic [7:0] RST_ESCAPE_CODE         = 8'd219;
    localparam logic [7:0] RST_ESCAPED_END_CODE    = 8'd220;
    localparam logic [7:0] RST_ESCAPED_ESCAPE_CODE = 8'd221;
    localparam logic [7:0] RST_CRC_SEED            = 8'd222;

    // Reflected CRC-8 (poly 0x31) step constants
    localparam logic [7:0] CRC_XOR  = 8'h18;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] CRC_MASK = 8'h7f;

    // Packet slots with fixed meaning
    localparam logic [8:0] SLOT_START   = 9'd0;
    localparam logic [8:0] SLOT_ADDRESS = 9'd1;
    localparam logic [8:0] SLOT_COMMAND = 9'd2;
    localparam logic [8:0] SLOT_LENGTH  = 9'd3;
    // Header bytes ahead of the payload
    localparam logic [8:0] HDR_BYTES    = 9'd4;

    // Configuration register file
    typedef struct packed {
        logic [7:0] frame_end_code;
        logic [7:0] escape_code;
        logic [7:0] escaped_end_code;
        logic [7:0] escaped_escape_code;
        logic [7:0] crc_seed;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [8:0] slot;
        logic [7:0] value;
        logic       frame_good;
        logic       frame_bad;
        logic [8:0] frame_length;
        logic       last_of_run;
    } t_result;

    // Fold one byte into the CRC, LSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                            input logic [7:0] byte_in);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc_in;
        b   = byte_in;
        for (int i = 0; i < 8; i++) begin
            if ((b[0] ^ crc[0]) == 1'b1) begin
                crc = ((crc ^ CRC_XOR) >> 1) | CRC_TOP;
            end else begin
                crc = (crc >> 1) & CRC_MASK;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/wfr_deframe.sv =====
// ----------------------------------------------------------------------------
// wfr_deframe
// Frame state and unstuffing logic: one received byte in, up to two results out.
// ----------------------------------------------------------------------------
module wfr_deframe
    import wfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic [1:0] o_res_cnt,
    output t_result    o_res0,
    output t_result    o_res1
);

    // Frame state
    logic [8:0] r_pos;
    logic       r_esc;
    logic [7:0] r_crc;
    logic [7:0] r_plen;
    logic [8:0] n_pos;
    logic       n_esc;
    logic [7:0] n_crc;
    logic [7:0] n_plen;

    logic [7:0] byte_c;
    logic [7:0] byte_lo7;
    logic       byte_ok;
    logic [8:0] end_pos;

    // Decode one byte against the current frame state
    always_comb begin
        n_pos     = r_pos;
        n_esc     = r_esc;
        n_crc     = r_crc;
        n_plen    = r_plen;
        o_res_cnt = 2'd0;
        o_res0    = '0;
        o_res1    = '0;
        byte_c    = i_rx_byte;
        byte_ok   = 1'b1;
        end_pos   = {1'b0, r_plen} + HDR_BYTES;

        if (i_rx_byte == i_cfg.frame_end_code) begin
            // start code always restarts the frame
            n_esc        = 1'b0;
            n_crc        = crc_fold(i_cfg.crc_seed, i_rx_byte);
            n_pos        = SLOT_ADDRESS;
            o_res0.slot  = SLOT_START;
            o_res0.value = i_rx_byte;
            o_res_cnt    = 2'd1;
        end else if (i_rx_byte == i_cfg.escape_code) begin
            n_esc = 1'b1;
        end else begin
            // restore escaped byte, drop on unknown follower
            if (r_esc) begin
                n_esc = 1'b0;
                if (i_rx_byte == i_cfg.escaped_end_code) begin
                    byte_c = i_cfg.frame_end_code;
                end else if (i_rx_byte == i_cfg.escaped_escape_code) begin
                    byte_c = i_cfg.escape_code;
                end else begin
                    byte_ok = 1'b0;
                end
            end
        end

        byte_lo7 = byte_c & CRC_MASK;

        if (i_rx_byte != i_cfg.frame_end_code && i_rx_byte != i_cfg.escape_code
                && byte_ok) begin
            if (r_pos == SLOT_ADDRESS) begin
                if (byte_c[7]) begin
                    // explicit address
                    o_res0.slot  = SLOT_ADDRESS;
                    o_res0.value = byte_lo7;
                    n_crc        = crc_fold(r_crc, byte_lo7);
                    n_pos        = SLOT_COMMAND;
                    o_res_cnt    = 2'd1;
                end else begin
                    // insert address 0, byte is the command
                    o_res0.slot  = SLOT_ADDRESS;
                    o_res0.value = 8'd0;
                    o_res1.slot  = SLOT_COMMAND;
                    o_res1.value = byte_lo7;
                    n_crc        = crc_fold(crc_fold(r_crc, 8'd0), byte_lo7);
                    n_pos        = SLOT_LENGTH;
                    o_res_cnt    = 2'd2;
                end
            end else if (r_pos == SLOT_COMMAND) begin
                o_res0.slot  = SLOT_COMMAND;
                o_res0.value = byte_lo7;
                n_crc        = crc_fold(r_crc, byte_lo7);
                n_pos        = SLOT_LENGTH;
                o_res_cnt    = 2'd1;
            end else if (r_pos == SLOT_LENGTH) begin
                n_plen       = byte_c;
                o_res0.slot  = SLOT_LENGTH;
                o_res0.value = byte_c;
                n_crc        = crc_fold(r_crc, byte_c);
                n_pos        = r_pos + 9'd1;
                o_res_cnt    = 2'd1;
            end else if (r_pos > SLOT_LENGTH && r_pos < end_pos) begin
                // payload byte
                o_res0.slot  = r_pos;
                o_res0.value = byte_c;
                n_crc        = crc_fold(r_crc, byte_c);
                n_pos        = r_pos + 9'd1;
                o_res_cnt    = 2'd1;
            end else if (r_pos == end_pos) begin
                // CRC byte, not folded in
                o_res0.slot  = end_pos;
                o_res0.value = byte_c;
                o_res_cnt    = 2'd1;
                if (byte_c == r_crc) begin
                    o_res0.frame_good   = 1'b1;
                    o_res0.frame_length = end_pos + 9'd1;
                    n_pos               = end_pos + 9'd1;
                end else begin
                    o_res0.frame_bad = 1'b1;
                    n_pos            = SLOT_START;
                    n_esc            = 1'b0;
                    n_crc            = 8'd0;
                end
            end
        end

        // mark the final result of this byte
        if (o_res_cnt == 2'd2) begin
            o_res1.last_of_run = 1'b1;
        end else begin
            o_res0.last_of_run = 1'b1;
        end
    end

    // State update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= SLOT_START;
            r_esc  <= 1'b0;
            r_crc  <= 8'd0;
            r_plen <= 8'd0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_esc  <= n_esc;
            r_crc  <= n_crc;
            r_plen <= n_plen;
        end
    end

endmodule

// ===== rtl/core/wake_frame_receiver.sv =====
// A result is registered and offered on the output in the cycle after its byte is accepted.
// One byte per cycle while the output takes results; a command byte with an inserted address gives
//   two results and holds the input while the second drains.
// The two-entry result buffer sets the rate: a byte is taken only when it can hold both.
// Reset (synchronous, active low) clears frame position, escape flag, CRC and the
//   result buffer, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// wake_frame_receiver
// Byte-wise deframer for stuffed serial frames with CRC-8 check.
// ----------------------------------------------------------------------------
module wake_frame_receiver
    import wfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result output
    output logic       o_valid,
    input  logic       i_stall,
    output logic [8:0] o_slot,
    output logic [7:0] o_value,
    output logic       o_frame_good,
    output logic       o_frame_bad,
    output logic [8:0] o_frame_length,
    output logic       o_last_of_run,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_cnt;
    logic       pop;
    logic       accept;
    logic [1:0] res_cnt;
    t_result    res0;
    t_result    res1;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_end_code      <= RST_FRAME_END_CODE;
            r_cfg.escape_code         <= RST_ESCAPE_CODE;
            r_cfg.escaped_end_code    <= RST_ESCAPED_END_CODE;
            r_cfg.escaped_escape_code <= RST_ESCAPED_ESCAPE_CODE;
            r_cfg.crc_seed            <= RST_CRC_SEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_END_CODE:      r_cfg.frame_end_code      <= i_cfg_data;
                CFG_ESCAPE_CODE:         r_cfg.escape_code         <= i_cfg_data;
                CFG_ESCAPED_END_CODE:    r_cfg.escaped_end_code    <= i_cfg_data;
                CFG_ESCAPED_ESCAPE_CODE: r_cfg.escaped_escape_code <= i_cfg_data;
                CFG_CRC_SEED:            r_cfg.crc_seed            <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshakes: take a byte only when the buffer will be empty after this cycle
    assign pop     = o_valid && !i_stall;
    assign o_stall = !((r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_stall));
    assign accept  = i_valid && !o_stall;

    wfr_deframe u_deframe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_res_cnt (res_cnt),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    // Two-entry result buffer, head drives the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= res_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q0 <= res0;
            r_q1 <= res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_valid        = (r_cnt != 2'd0);
    assign o_slot         = r_q0.slot;
    assign o_value        = r_q0.value;
    assign o_frame_good   = r_q0.frame_good;
    assign o_frame_bad    = r_q0.frame_bad;
    assign o_frame_length = r_q0.frame_length;
    assign o_last_of_run  = r_q0.last_of_run;

`ifndef ASSERT_OFF
    // buffer never holds more than two results
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    // the first of a pair is never the last of its run
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !r_q0.last_of_run && r_q1.last_of_run)
        else $error("result pair out of order");

    // good and bad flags are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_good && o_frame_bad))
        else $error("frame good and bad both set");

    // length is reported only with a good frame
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_good |-> o_frame_length == 9'd0)
        else $error("frame length without good frame");
`endif

endmodule

// ===== tb/wake_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// wake_frame_receiver testbench
// Drives stuffed frames, broken frames and noise into the deframer under
// several code settings and idle patterns. A scoreboard decodes every
// accepted byte on its own and matches each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import wfr_pkg::*;
();

    // Reflected CRC-8, poly 0x31: data folded in first, then shifted out LSB first
    function automatic logic [7:0] crc8_fold_byte(input logic [7:0] crc_in,
                                                  input logic [7:0] data);
        logic [7:0] acc;
        acc = crc_in ^ data;
        for (int n = 0; n < 8; n++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ 8'h8c;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    class frame_scoreboard;
        t_cfg       cfg;
        logic [8:0] position;
        logic       escape_armed;
        logic [7:0] crc;
        logic [7:0] payload_len;
        t_result    due_results[$];
        t_result    burst[$];
        int         failures;

        function new();
            cfg.frame_end_code      = RST_FRAME_END_CODE;
            cfg.escape_code         = RST_ESCAPE_CODE;
            cfg.escaped_end_code    = RST_ESCAPED_END_CODE;
            cfg.escaped_escape_code = RST_ESCAPED_ESCAPE_CODE;
            cfg.crc_seed            = RST_CRC_SEED;
            position     = '0;
            escape_armed = 1'b0;
            crc          = '0;
            payload_len  = '0;
            failures     = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [7:0] data);
            case (index)
                CFG_FRAME_END_CODE:      cfg.frame_end_code = data;
                CFG_ESCAPE_CODE:         cfg.escape_code = data;
                CFG_ESCAPED_END_CODE:    cfg.escaped_end_code = data;
                CFG_ESCAPED_ESCAPE_CODE: cfg.escaped_escape_code = data;
                CFG_CRC_SEED:            cfg.crc_seed = data;
                default: ;
            endcase
        endfunction

        function void add(logic [8:0] slot, logic [7:0] value, logic good, logic bad,
                          logic [8:0] length);
            t_result r;
            r.slot         = slot;
            r.value        = value;
            r.frame_good   = good;
            r.frame_bad    = bad;
            r.frame_length = length;
            r.last_of_run  = 1'b0;
            burst.push_back(r);
        endfunction

        // Store one byte at the current slot and fold it into the CRC
        function void keep(logic [7:0] value);
            add(position, value, 1'b0, 1'b0, 9'd0);
            crc      = crc8_fold_byte(crc, value);
            position = position + 9'd1;
        endfunction

        // Decode one accepted byte and queue the results it causes
        function void decode_byte(logic [7:0] rx);
            logic [7:0] c;
            logic [8:0] end_pos;
            logic       dropped;
            t_result    r;
            c       = rx;
            dropped = 1'b0;
            burst.delete();
            if (c == cfg.frame_end_code) begin
                position     = '0;
                escape_armed = 1'b0;
                crc          = cfg.crc_seed;
                keep(c);
            end else if (c == cfg.escape_code) begin
                escape_armed = 1'b1;
            end else begin
                if (escape_armed) begin
                    escape_armed = 1'b0;
                    if (c == cfg.escaped_end_code) begin
                        c = cfg.frame_end_code;
                    end else if (c == cfg.escaped_escape_code) begin
                        c = cfg.escape_code;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                if (!dropped) begin
                    end_pos = {1'b0, payload_len} + HDR_BYTES;
                    if (position == SLOT_ADDRESS) begin
                        // top bit clear: no address byte, address 0 goes in first
                        if (!c[7]) begin
                            keep(8'h00);
                        end
                        keep({1'b0, c[6:0]});
                    end else if (position == SLOT_COMMAND) begin
                        keep({1'b0, c[6:0]});
                    end else if (position == SLOT_LENGTH) begin
                        payload_len = c;
                        keep(c);
                    end else if (position > SLOT_LENGTH && position < end_pos) begin
                        keep(c);
                    end else if (position == end_pos) begin
                        if (c == crc) begin
                            // good frame is held until the next start code
                            add(end_pos, c, 1'b1, 1'b0, end_pos + 9'd1);
                            position = end_pos + 9'd1;
                        end else begin
                            add(end_pos, c, 1'b0, 1'b1, 9'd0);
                            position     = '0;
                            escape_armed = 1'b0;
                            crc          = '0;
                        end
                    end
                end
            end
            if (burst.size() > 0) begin
                r = burst.pop_back();
                r.last_of_run = 1'b1;
                burst.push_back(r);
            end
            foreach (burst[k]) due_results.push_back(burst[k]);
        endfunction

        function void check_output(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: slot %0d value %h", got.slot, got.value);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.slot !== want.slot || got.value !== want.value ||
                got.frame_good !== want.frame_good || got.frame_bad !== want.frame_bad ||
                got.frame_length !== want.frame_length ||
                got.last_of_run !== want.last_of_run) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch (exp/act): slot %0d/%0d value %h/%h good %b/%b",
                             want.slot, got.slot, want.value, got.value,
                             want.frame_good, got.frame_good);
                    $display("    bad %b/%b length %0d/%0d last %b/%b",
                             want.frame_bad, got.frame_bad, want.frame_length,
                             got.frame_length, want.last_of_run, got.last_of_run);
                end
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function bit clean();
            return failures == 0 && due_results.size() == 0;
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [8:0] o_slot;
    logic [7:0] o_value;
    logic       o_frame_good;
    logic       o_frame_bad;
    logic [8:0] o_frame_length;
    logic       o_last_of_run;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = CFG_FRAME_END_CODE;
    logic [7:0] i_cfg_data = 8'h00;

    frame_scoreboard sb;
    t_cfg            cur;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              sent_bytes = 0;
    logic            valid_held = 1'b0;
    int unsigned     cycle_count = 0;

    wake_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot         (o_slot),
        .o_value        (o_value),
        .o_frame_good   (o_frame_good),
        .o_frame_bad    (o_frame_bad),
        .o_frame_length (o_frame_length),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.slot         = o_slot;
            got.value        = o_value;
            got.frame_good   = o_frame_good;
            got.frame_bad    = o_frame_bad;
            got.frame_length = o_frame_length;
            got.last_of_run  = o_last_of_run;
            sb.check_output(got);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One byte transfer, then an optional random gap
    task automatic push_rx_byte(input logic [7:0] b);
        int gap;
        i_rx_byte <= b;
        if (!valid_held) begin
            i_valid   <= 1'b1;
            valid_held = 1'b1;
        end
        do @(posedge i_clk); while (o_stall);
        sb.decode_byte(b);
        sent_bytes++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid   <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_stuffed(input logic [7:0] v);
        if (v == cur.frame_end_code) begin
            push_rx_byte(cur.escape_code);
            push_rx_byte(cur.escaped_end_code);
        end else if (v == cur.escape_code) begin
            push_rx_byte(cur.escape_code);
            push_rx_byte(cur.escaped_escape_code);
        end else begin
            push_rx_byte(v);
        end
    endtask

    // Build one frame with its CRC; cut > 0 keeps only that many bytes after the start
    task automatic send_frame(input bit has_addr, input logic [6:0] addr,
                              input logic [7:0] cmd, input logic [7:0] pl[$],
                              input bit crc_good, input int cut);
        logic [7:0] raw[$];
        logic [7:0] crc;
        crc = crc8_fold_byte(cur.crc_seed, cur.frame_end_code);
        if (has_addr) begin
            raw.push_back({1'b1, addr});
            raw.push_back(cmd);
            crc = crc8_fold_byte(crc, {1'b0, addr});
        end else begin
            raw.push_back({1'b0, cmd[6:0]});
            crc = crc8_fold_byte(crc, 8'h00);
        end
        crc = crc8_fold_byte(crc, {1'b0, cmd[6:0]});
        raw.push_back(8'(pl.size()));
        crc = crc8_fold_byte(crc, 8'(pl.size()));
        foreach (pl[k]) begin
            raw.push_back(pl[k]);
            crc = crc8_fold_byte(crc, pl[k]);
        end
        raw.push_back(crc_good ? crc : crc ^ 8'($urandom_range(255, 1)));
        if (cut > 0) begin
            while (raw.size() > cut) void'(raw.pop_back());
        end
        push_rx_byte(cur.frame_end_code);
        foreach (raw[k]) send_stuffed(raw[k]);
    endtask

    task automatic stop_input();
        if (valid_held) begin
            i_valid   <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    // Wait for every expected result, then let a byte with no result settle
    task automatic drain_outputs();
        stop_input();
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        logic [2:0] idx[5];
        logic [7:0] val[5];
        idx = '{CFG_FRAME_END_CODE, CFG_ESCAPE_CODE, CFG_ESCAPED_END_CODE,
                CFG_ESCAPED_ESCAPE_CODE, CFG_CRC_SEED};
        val = '{c.frame_end_code, c.escape_code, c.escaped_end_code,
                c.escaped_escape_code, c.crc_seed};
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
        cur = c;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 54; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    // Four distinct codes so that stuffing is unambiguous
    function automatic t_cfg distinct_cfg();
        t_cfg c;
        c.frame_end_code = 8'($urandom_range(255));
        do c.escape_code = 8'($urandom_range(255));
        while (c.escape_code == c.frame_end_code);
        do c.escaped_end_code = 8'($urandom_range(255));
        while (c.escaped_end_code == c.frame_end_code || c.escaped_end_code == c.escape_code);
        do c.escaped_escape_code = 8'($urandom_range(255));
        while (c.escaped_escape_code == c.frame_end_code ||
               c.escaped_escape_code == c.escape_code ||
               c.escaped_escape_code == c.escaped_end_code);
        c.crc_seed = 8'($urandom_range(255));
        return c;
    endfunction

    // Payload bytes lean on the special codes to exercise stuffing
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(7))
            0:       return cur.frame_end_code;
            1:       return cur.escape_code;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] code_byte();
        case ($urandom_range(4))
            0:       return cur.frame_end_code;
            1:       return cur.escape_code;
            2:       return cur.escaped_end_code;
            3:       return cur.escaped_escape_code;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly good frames; the rest bad CRCs, cut frames, noise and escape misuse
    task automatic run_traffic(input int n_bytes, input bit with_long);
        int         first;
        int         pick;
        int         len;
        logic [7:0] pl[$];
        first = sent_bytes;
        if (with_long) begin
            for (int k = 0; k < 255; k++) pl.push_back(payload_byte());
            send_frame(1'b1, 7'($urandom_range(127)), 8'($urandom_range(255)), pl, 1'b1, 0);
        end
        while (sent_bytes - first < n_bytes) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
            pl.delete();
            for (int k = 0; k < len; k++) pl.push_back(payload_byte());
            if (pick < 70) begin
                send_frame(1'($urandom_range(1)), 7'($urandom_range(127)),
                           8'($urandom_range(255)), pl, 1'b1, 0);
            end else if (pick < 78) begin
                send_frame(1'($urandom_range(1)), 7'($urandom_range(127)),
                           8'($urandom_range(255)), pl, 1'b0, 0);
            end else if (pick < 85) begin
                send_frame(1'($urandom_range(1)), 7'($urandom_range(127)),
                           8'($urandom_range(255)), pl, 1'b1, $urandom_range(len + 3, 1));
            end else if (pick < 92) begin
                repeat ($urandom_range(4, 1)) push_rx_byte(8'($urandom_range(255)));
            end else if (pick < 96) begin
                push_rx_byte(cur.escape_code);
                if ($urandom_range(1)) push_rx_byte(cur.escape_code);
                push_rx_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1)) push_rx_byte(code_byte());
            end
        end
    endtask

    initial begin
        t_cfg       c;
        logic [7:0] pl[$];
        sb = new();
        cur = sb.cfg;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Addressed frame, top bits set, both stuffed codes in the payload
        pl = '{cur.frame_end_code, cur.escape_code};
        send_frame(1'b1, 7'h7f, 8'hff, pl, 1'b1, 0);
        // held after a good CRC
        push_rx_byte(8'h33);
        // no address byte, empty payload, bad CRC
        pl.delete();
        send_frame(1'b0, 7'h00, 8'h00, pl, 1'b0, 0);
        // ignored at position 0
        push_rx_byte(8'h12);
        // start code right after an escape still starts a frame
        push_rx_byte(cur.escape_code);
        push_rx_byte(cur.frame_end_code);
        push_rx_byte(8'h81);
        // repeated escape, then an escaped start code as command
        push_rx_byte(cur.escape_code);
        push_rx_byte(cur.escape_code);
        push_rx_byte(cur.escaped_end_code);
        // bad follower is dropped
        push_rx_byte(cur.escape_code);
        push_rx_byte(8'h55);
        push_rx_byte(8'h00);
        push_rx_byte(8'h00);

        for (int p = 0; p < 8; p++) begin
            drain_outputs();
            case (p)
                0: begin
                    c.frame_end_code      = 8'h00;
                    c.escape_code         = 8'hff;
                    c.escaped_end_code    = 8'h01;
                    c.escaped_escape_code = 8'hfe;
                    c.crc_seed            = 8'h00;
                end
                1: begin
                    c.frame_end_code      = 8'hff;
                    c.escape_code         = 8'h00;
                    c.escaped_end_code    = 8'hfe;
                    c.escaped_escape_code = 8'h01;
                    c.crc_seed            = 8'hff;
                end
                4: begin
                    // overlapping codes: start test wins over escape test
                    c = distinct_cfg();
                    c.escape_code         = c.frame_end_code;
                    c.escaped_escape_code = c.escaped_end_code;
                end
                7: begin
                    c.frame_end_code      = RST_FRAME_END_CODE;
                    c.escape_code         = RST_ESCAPE_CODE;
                    c.escaped_end_code    = RST_ESCAPED_END_CODE;
                    c.escaped_escape_code = RST_ESCAPED_ESCAPE_CODE;
                    c.crc_seed            = RST_CRC_SEED;
                end
                default: c = distinct_cfg();
            endcase
            load_cfg(c);
            set_idling(t_idle_mode'(p % 4));
            run_traffic(30, p == 3);
        end

        drain_outputs();
        if (sb.clean()) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== wake_frame_receiver.f =====
rtl/core/wfr_pkg.sv
rtl/core/wfr_deframe.sv
rtl/core/wake_frame_receiver.sv
tb/wake_frame_receiver_tb.sv
